[hdl/bqhc_pkg.sv]
package bqhc_pkg;

   localparam int PIXEL_W       = 8;
   localparam int DIM_CFG_W     = 12;
   localparam int TALLY_W       = 23;
   localparam int HOLE_W        = 22;
   localparam int RSP_TDATA_W   = 72;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int WINDOW_COLS   = 2;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;

   localparam logic [PIXEL_W-1:0]   THRESHOLD_RST    = 8'd80;
   localparam logic [DIM_CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [DIM_CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

   localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

   // window population codes
   localparam logic [2:0] ONES_EXTERNAL = 3'd1;
   localparam logic [2:0] ONES_INTERNAL = 3'd3;

   typedef enum logic [1:0] {
      REG_THRESHOLD    = 2'd0,
      REG_FRAME_WIDTH  = 2'd1,
      REG_FRAME_HEIGHT = 2'd2
   } reg_idx_type;

   // per-pixel control that travels down the cell row
   typedef struct packed {
      logic count;
      logic last;
   } tag_type;

   typedef struct packed {
      logic    up;
      logic    low;
      tag_type tag;
   } cell_type;

   typedef struct packed {
      logic               valid;
      logic [TALLY_W-1:0] ext;
      logic [TALLY_W-1:0] internal;
   } result_type;

endpackage

[hdl/bqhc_line_buf.sv]
module bqhc_line_buf #(
   parameter int DEPTH = bqhc_pkg::MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     wr_bit,
   output logic                     rd_bit
);
   import bqhc_pkg::*;

   logic line_ff [DEPTH];
   logic rd_bit_ff;

   // read returns the bit of the prior row before this pixel overwrites it
   always_ff @(posedge clock) begin
      if (en) begin
         rd_bit_ff     <= line_ff[addr];
         line_ff[addr] <= wr_bit;
      end
   end

   assign rd_bit = rd_bit_ff;

endmodule

[hdl/bqhc_cell.sv]
module bqhc_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  bqhc_pkg::cell_type d,
   output bqhc_pkg::cell_type q,
   output logic [1:0]         ones
);
   import bqhc_pkg::*;

   cell_type col_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= d;
      end
   end

   assign q    = col_ff;
   assign ones = {1'b0, col_ff.up} + {1'b0, col_ff.low};

endmodule

[hdl/bqhc_tally.sv]
module bqhc_tally (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 win_valid,
   input  bqhc_pkg::tag_type    win_tag,
   input  logic [1:0]           right_ones,
   input  logic [1:0]           left_ones,
   output bqhc_pkg::result_type result
);
   import bqhc_pkg::*;

   logic [TALLY_W-1:0] ext_ff, ext_in;
   logic [TALLY_W-1:0] int_ff, int_in;
   logic [2:0]         ones;
   logic               res_valid_ff, res_valid_in;
   logic [TALLY_W-1:0] res_ext_ff, res_int_ff;

   assign ones = {1'b0, right_ones} + {1'b0, left_ones};

   always_comb begin
      ext_in = ext_ff;
      int_in = int_ff;
      if (win_valid && win_tag.count) begin
         if (ones == ONES_INTERNAL && int_ff != TALLY_MAX) begin
            int_in = int_ff + 1'b1;
         end
         if (ones == ONES_EXTERNAL && ext_ff != TALLY_MAX) begin
            ext_in = ext_ff + 1'b1;
         end
      end
      res_valid_in = win_valid && win_tag.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff       <= '0;
         int_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         if (res_valid_in) begin
            ext_ff <= '0;
            int_ff <= '0;
         end else begin
            ext_ff <= ext_in;
            int_ff <= int_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid_in) begin
         res_ext_ff <= ext_in;
         res_int_ff <= int_in;
      end
   end

   assign result.valid    = res_valid_ff;
   assign result.ext      = res_ext_ff;
   assign result.internal = res_int_ff;

endmodule

[hdl/bit_quad_hole_counter_unit.sv]
// bit-quad hole counter: thresholds a raster stream of 8-bit pixels and counts
// the 2x2 windows with one set pixel (external corners) and with three set
// pixels (internal corners); holes = (external - internal) / 4, rounded to zero.
// req channel: one pixel per transaction in req_tdata[7:0], raster order.
// rsp channel: one transaction per frame, after the frame's last pixel.
// csr port: threshold at 0x0, frame_width at 0x4, frame_height at 0x8; change
// them only while no pixel of an unfinished frame is in flight.
// throughput: one pixel per clock unless a frame-ending pixel is held off; the
// line buffer is one bit wide with a single read-before-write port, so each
// pixel costs one memory access.
// result path: the last pixel's transaction passes the line buffer read, window
// cell row, tally register and output register before rsp_tvalid rises.
// stall: while a result waits on rsp_tready, pixels of the next frame keep
// flowing; a frame-ending pixel is held off while an earlier frame end is still
// in the pipe or in the output register, so a frame's result leaves the output
// register before the next frame's last pixel is taken.
// reset: tallies, row and column position and pipeline valids clear, the
// registers return to 80 / 640 / 480; the line buffer needs no clearing pass.
module bit_quad_hole_counter_unit #(
   parameter int MAX_WIDTH  = bqhc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bqhc_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bqhc_pkg::PIXEL_W-1:0]         req_tdata,  // pixel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // hole_count [21:0], external_corners [44:22], internal_corners [67:45]
   output logic [bqhc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bqhc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bqhc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bqhc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import bqhc_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int POS_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int CMP_W  = ((POS_W > DIM_CFG_W) ? POS_W : DIM_CFG_W) + 1;
   localparam int DIFF_W = TALLY_W + 1;

   // configuration
   logic [PIXEL_W-1:0]   threshold_ff;
   logic [DIM_CFG_W-1:0] frame_width_ff, frame_height_ff;
   reg_idx_type          csr_idx;
   logic                 csr_wr;

   assign csr_idx    = reg_idx_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RST;
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_THRESHOLD:    threshold_ff    <= csr_pwdata[PIXEL_W-1:0];
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[DIM_CFG_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[DIM_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_THRESHOLD:    csr_prdata = CSR_DATA_W'(threshold_ff);
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // frame size clamped to 1..max
   logic [CMP_W-1:0] width_cfg, height_cfg, width_eff, height_eff;

   assign width_cfg  = CMP_W'(frame_width_ff);
   assign height_cfg = CMP_W'(frame_height_ff);

   always_comb begin
      priority if (width_cfg == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_cfg > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_cfg;
      end
      priority if (height_cfg == '0) begin
         height_eff = CMP_W'(1);
      end else if (height_cfg > CMP_W'(MAX_HEIGHT)) begin
         height_eff = CMP_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_cfg;
      end
   end

   // raster position
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             last_col, last_row, frame_end, accept, pix_bit;

   assign last_col  = (CMP_W'(col_ff) + CMP_W'(1)) >= width_eff;
   assign last_row  = (CMP_W'(row_ff) + CMP_W'(1)) >= height_eff;
   assign frame_end = last_col && last_row;
   assign accept    = req_tvalid && req_tready;
   assign pix_bit   = req_tdata > threshold_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage a: line buffer access
   logic    a_valid_ff;
   logic    a_bit_ff;
   tag_type a_tag_ff;
   logic    up_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_bit_ff       <= pix_bit;
         a_tag_ff.count <= (row_ff != '0) && (col_ff != '0);
         a_tag_ff.last  <= frame_end;
      end
   end

   bqhc_line_buf #(
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock  (clock),
      .en     (accept),
      .addr   (col_ff),
      .wr_bit (pix_bit),
      .rd_bit (up_bit)
   );

   // window cell row: cell 0 is the current column, cell 1 the left one
   cell_type   cell_d [WINDOW_COLS];
   cell_type   cell_q [WINDOW_COLS];
   logic [1:0] cell_ones [WINDOW_COLS];
   logic       b_valid_ff;

   assign cell_d[0] = '{up: up_bit, low: a_bit_ff, tag: a_tag_ff};

   for (genvar i = 0; i < WINDOW_COLS; i++) begin : g_cell
      if (i > 0) begin : g_link
         assign cell_d[i] = cell_q[i-1];
      end
      bqhc_cell u_cell (
         .clock    (clock),
         .shift_en (a_valid_ff),
         .d        (cell_d[i]),
         .q        (cell_q[i]),
         .ones     (cell_ones[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   result_type result;

   bqhc_tally u_tally (
      .clock      (clock),
      .reset      (reset),
      .win_valid  (b_valid_ff),
      .win_tag    (cell_q[0].tag),
      .right_ones (cell_ones[0]),
      .left_ones  (cell_ones[WINDOW_COLS-1]),
      .result     (result)
   );

   // output register
   logic               rsp_valid_ff;
   logic [TALLY_W-1:0] out_ext_ff, out_int_ff;
   logic               end_in_flight;

   // a frame end already in the pipe or waiting at the output holds off the next one
   assign end_in_flight = rsp_valid_ff || result.valid
                          || (a_valid_ff && a_tag_ff.last)
                          || (b_valid_ff && cell_q[0].tag.last);
   assign req_tready    = !(frame_end && end_in_flight);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         out_ext_ff <= result.ext;
         out_int_ff <= result.internal;
      end
   end

   // signed quotient by four, rounded toward zero
   logic signed [DIFF_W-1:0] diff, diff_adj;
   logic        [HOLE_W-1:0] hole_count;

   assign diff       = $signed({1'b0, out_ext_ff}) - $signed({1'b0, out_int_ff});
   assign diff_adj   = diff + (diff[DIFF_W-1] ? DIFF_W'(3) : DIFF_W'(0));
   assign hole_count = diff_adj[DIFF_W-1:2];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - HOLE_W - 2 * TALLY_W){1'b0}},
                        out_int_ff, out_ext_ff, hole_count};

   a_end_reaches_output : assert property (@(posedge clock) disable iff (reset)
      (accept && frame_end) |-> ##4 rsp_valid_ff)
      else $error("frame end did not reach the output");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      result.valid |-> !rsp_valid_ff)
      else $error("result arrived while output still held one");

   a_single_end_in_pipe : assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_tag_ff.last) |-> !(b_valid_ff && cell_q[0].tag.last))
      else $error("two frame ends in the pipeline");

endmodule
